@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the scheduler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("scheduler assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
   else $error("scheduler assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ rtl/core/cpjs_pkg.sv @@
// Types, constants and the control store of the prefill job scheduler.
package cpjs_pkg;

   localparam int MAX_JOBS_DEF = 16;
   localparam int CMD_W = 2;
   localparam int TOK_W = 20;
   localparam int IDX_IN_W = 4;
   localparam int CHUNK_W = 16;
   localparam int ACT_W = 5;
   localparam int ENTRY_W = 1 + 2 * TOK_W;
   localparam logic [CHUNK_W-1:0] DEFAULT_CHUNK = 16'd512;

   typedef enum logic [CMD_W-1:0] {
      CMD_SUBMIT = 2'd0,
      CMD_NEXT   = 2'd1,
      CMD_SCHED  = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STEP_IDLE  = 3'd0,
      STEP_SUB   = 3'd1,
      STEP_ERR   = 3'd2,
      STEP_EMPTY = 3'd3,
      STEP_RD    = 3'd4,
      STEP_CALC  = 3'd5,
      STEP_EMIT  = 3'd6
   } step_type;

   typedef enum logic [1:0] {
      OUT_SUBMIT = 2'd0,
      OUT_ERROR  = 2'd1,
      OUT_EMPTY  = 2'd2,
      OUT_JOB    = 2'd3
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      logic        rd;
      logic        calc;
      logic        emit;
      logic        wr;
      logic        ret;
      logic        loop;
      out_sel_type out_sel;
      step_type    target;
   } ctrl_word_type;

   typedef struct packed {
      logic     req_valid;
      logic     out_free;
      logic     more;
      step_type entry_step;
   } dp_status_type;

   // Control store: one control word per step of the microprogram.
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type cw;
      cw = '0;
      unique case (step)
         STEP_IDLE: begin
            cw.accept = 1'b1;
         end
         STEP_SUB: begin
            cw.emit = 1'b1;
            cw.wr = 1'b1;
            cw.ret = 1'b1;
            cw.out_sel = OUT_SUBMIT;
         end
         STEP_ERR: begin
            cw.emit = 1'b1;
            cw.ret = 1'b1;
            cw.out_sel = OUT_ERROR;
         end
         STEP_EMPTY: begin
            cw.emit = 1'b1;
            cw.ret = 1'b1;
            cw.out_sel = OUT_EMPTY;
         end
         STEP_RD: begin
            cw.rd = 1'b1;
         end
         STEP_CALC: begin
            cw.calc = 1'b1;
         end
         STEP_EMIT: begin
            cw.emit = 1'b1;
            cw.wr = 1'b1;
            cw.ret = 1'b1;
            cw.loop = 1'b1;
            cw.out_sel = OUT_JOB;
            cw.target = STEP_RD;
         end
         default: begin
            cw = '0;
         end
      endcase
      return cw;
   endfunction

endpackage

@@ rtl/core/cpjs_req_if.sv @@
// Request channel interface of the scheduler.
interface cpjs_req_if;
   import cpjs_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [TOK_W-1:0]    token_count;
   logic [IDX_IN_W-1:0] job_index;
   logic [TOK_W-1:0]    decode_budget;

   modport source (output valid, output command, output token_count, output job_index,
                   output decode_budget, input ready);
   modport sink (input valid, input command, input token_count, input job_index,
                 input decode_budget, output ready);
endinterface

@@ rtl/core/cpjs_rsp_if.sv @@
// Response channel interface of the scheduler.
interface cpjs_rsp_if;
   import cpjs_pkg::*;
   logic                valid;
   logic                ready;
   logic                status;
   logic [IDX_IN_W-1:0] job_id;
   logic [CHUNK_W-1:0]  chunk_tokens;
   logic                done_flag;
   logic [TOK_W-1:0]    prefilled_tokens;
   logic [TOK_W-1:0]    job_total;
   logic [TOK_W-1:0]    decode_tokens;
   logic [ACT_W-1:0]    active_jobs;
   logic                last;

   modport source (output valid, output status, output job_id, output chunk_tokens,
                   output done_flag, output prefilled_tokens, output job_total,
                   output decode_tokens, output active_jobs, output last, input ready);
   modport sink (input valid, input status, input job_id, input chunk_tokens,
                 input done_flag, input prefilled_tokens, input job_total,
                 input decode_tokens, input active_jobs, input last, output ready);
endinterface

@@ rtl/core/cpjs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cpjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/cpjs_sequencer.sv @@
// Microprogram step counter: fetches control words and takes the jumps.
module cpjs_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  cpjs_pkg::dp_status_type status,
   output cpjs_pkg::ctrl_word_type ctrl
);
   import cpjs_pkg::*;

   step_type step_ff;
   step_type step_in;

   assign ctrl = ucode(step_ff);

   always_comb begin
      step_in = step_ff;
      priority if (ctrl.accept) begin
         if (status.req_valid) begin
            step_in = status.entry_step;
         end
      end else if (ctrl.emit) begin
         // An emit step holds until the output register can take the result.
         if (status.out_free) begin
            priority if (ctrl.loop && status.more) begin
               step_in = ctrl.target;
            end else if (ctrl.ret) begin
               step_in = STEP_IDLE;
            end else begin
               step_in = step_type'(step_ff + 3'd1);
            end
         end
      end else begin
         step_in = step_type'(step_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end
endmodule

@@ rtl/core/cpjs_datapath.sv @@
// Job table datapath: request latch, chunk arithmetic, counters and output register.
`include "assert_macros.svh"
module cpjs_datapath #(
   parameter int MAX_JOBS = cpjs_pkg::MAX_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [cpjs_pkg::CHUNK_W-1:0] csr_write_data,
   input  cpjs_pkg::ctrl_word_type      ctrl,
   output cpjs_pkg::dp_status_type      status,
   cpjs_req_if.sink                     req,
   cpjs_rsp_if.source                   rsp
);
   import cpjs_pkg::*;

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int XW = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
   localparam int AW = (CNT_W > ACT_W) ? CNT_W : ACT_W;
   localparam int SUM_W = CHUNK_W + CNT_W;
   localparam int DW = (SUM_W > TOK_W) ? SUM_W : TOK_W;

   // Latched request.
   cmd_type            cmd_ff;
   logic [TOK_W-1:0]   tok_ff;
   logic [TOK_W-1:0]   bud_ff;
   logic [IDX_IN_W-1:0] idx_ff;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   job_count_ff, job_count_in;
   logic [CHUNK_W-1:0] chunk_limit_ff;

   // Working copy of one table entry.
   logic [TOK_W-1:0]   tot_ff, prog_ff;
   logic               fin_ff;
   logic [CHUNK_W-1:0] chunk_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   act_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               status_ff;
   logic [IDX_IN_W-1:0] job_id_ff;
   logic [CHUNK_W-1:0] chunk_tokens_ff;
   logic               done_flag_ff;
   logic [TOK_W-1:0]   prefilled_ff, job_total_ff, decode_ff;
   logic [ACT_W-1:0]   active_ff;
   logic               last_ff;

   logic               accept, out_free, fire, more, sub_ok, bad_idx, advance;
   logic [XW-1:0]      idx_x, count_x, addr_x;
   logic [AW-1:0]      act_x;
   logic [DW-1:0]      sum_x, bud_x;
   logic [TOK_W-1:0]   dec_tokens;
   logic [CNT_W:0]     addr_next;
   step_type           entry_step;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
   logic [TOK_W-1:0]   q_tot, q_prog, rem;
   logic               q_fin, rem_le_lim;
   logic [CHUNK_W-1:0] lim, ch;

   cpjs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_JOBS),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ctrl.rd),
      .rd_addr(addr_ff),
      .rd_data(ram_rd_data)
   );

   assign req.ready = ctrl.accept;
   assign accept = req.valid && ctrl.accept;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign fire = ctrl.emit && out_free;

   assign idx_x = XW'(req.job_index);
   assign count_x = XW'(job_count_ff);
   assign addr_x = XW'(addr_ff);
   assign act_x = AW'(act_ff);
   assign bad_idx = idx_x >= count_x;
   assign sub_ok = (tok_ff != '0) && (job_count_ff < CNT_W'(MAX_JOBS));
   assign addr_next = (CNT_W + 1)'(addr_ff) + (CNT_W + 1)'(1);
   assign more = (cmd_ff == CMD_SCHED) && (addr_next < (CNT_W + 1)'(job_count_ff));

   always_comb begin
      unique case (cmd_type'(req.command))
         CMD_SUBMIT: entry_step = STEP_SUB;
         CMD_SCHED:  entry_step = (job_count_ff == '0) ? STEP_EMPTY : STEP_RD;
         CMD_NEXT,
         CMD_QUERY:  entry_step = bad_idx ? STEP_ERR : STEP_RD;
         default:    entry_step = STEP_ERR;
      endcase
   end

   assign status.req_valid = req.valid;
   assign status.out_free = out_free;
   assign status.more = more;
   assign status.entry_step = entry_step;

   // Chunk arithmetic on the entry just read. The remaining count fits the
   // limit exactly when this chunk finishes the job.
   assign {q_fin, q_prog, q_tot} = ram_rd_data;
   assign lim = (chunk_limit_ff == '0) ? DEFAULT_CHUNK : chunk_limit_ff;
   assign rem = q_tot - q_prog;
   assign rem_le_lim = rem <= TOK_W'(lim);
   assign ch = rem_le_lim ? rem[CHUNK_W-1:0] : lim;
   assign advance = (cmd_ff != CMD_QUERY);

   assign sum_x = DW'(sum_ff);
   assign bud_x = DW'(bud_ff);
   always_comb begin
      dec_tokens = '0;
      if (sum_x < bud_x) begin
         dec_tokens = TOK_W'(bud_x - sum_x);
      end
   end

   assign ram_wr_en = fire && ctrl.wr && ((ctrl.out_sel != OUT_SUBMIT) || sub_ok);
   assign ram_wr_addr = (ctrl.out_sel == OUT_SUBMIT) ? job_count_ff[IDX_W-1:0] : addr_ff;
   assign ram_wr_data = (ctrl.out_sel == OUT_SUBMIT) ? {1'b0, {TOK_W{1'b0}}, tok_ff}
                                                     : {fin_ff, prog_ff, tot_ff};

   always_comb begin
      addr_in = addr_ff;
      if (accept) begin
         addr_in = (cmd_type'(req.command) == CMD_SCHED) ? '0 : idx_x[IDX_W-1:0];
      end else if (fire && ctrl.loop && more) begin
         addr_in = addr_next[IDX_W-1:0];
      end
   end

   always_comb begin
      job_count_in = job_count_ff;
      if (fire && (ctrl.out_sel == OUT_SUBMIT) && sub_ok) begin
         job_count_in = job_count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff <= '0;
         chunk_limit_ff <= DEFAULT_CHUNK;
         rsp_valid_ff <= 1'b0;
         cmd_ff <= CMD_SUBMIT;
      end else begin
         job_count_ff <= job_count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            chunk_limit_ff <= csr_write_data;
         end
         if (accept) begin
            cmd_ff <= cmd_type'(req.command);
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (accept) begin
         tok_ff <= req.token_count;
         bud_ff <= req.decode_budget;
         idx_ff <= req.job_index;
         sum_ff <= '0;
         act_ff <= '0;
      end
      if (ctrl.calc) begin
         tot_ff <= q_tot;
         prog_ff <= q_prog;
         fin_ff <= q_fin;
         chunk_ff <= '0;
         if (advance && !q_fin) begin
            if (q_prog >= q_tot) begin
               fin_ff <= 1'b1;
            end else begin
               prog_ff <= q_prog + TOK_W'(ch);
               fin_ff <= rem_le_lim;
               chunk_ff <= ch;
               sum_ff <= sum_ff + SUM_W'(ch);
               act_ff <= act_ff + CNT_W'(1);
            end
         end
      end
      if (fire) begin
         status_ff <= 1'b0;
         job_id_ff <= '0;
         chunk_tokens_ff <= '0;
         done_flag_ff <= 1'b0;
         prefilled_ff <= '0;
         job_total_ff <= '0;
         decode_ff <= '0;
         active_ff <= '0;
         last_ff <= 1'b1;
         unique case (ctrl.out_sel)
            OUT_SUBMIT: begin
               if (sub_ok) begin
                  job_id_ff <= count_x[IDX_IN_W-1:0];
                  job_total_ff <= tok_ff;
               end else begin
                  status_ff <= 1'b1;
               end
            end
            OUT_ERROR: begin
               status_ff <= 1'b1;
               job_id_ff <= idx_ff;
               done_flag_ff <= 1'b1;
            end
            OUT_EMPTY: begin
               decode_ff <= bud_ff;
            end
            OUT_JOB: begin
               job_id_ff <= addr_x[IDX_IN_W-1:0];
               chunk_tokens_ff <= chunk_ff;
               done_flag_ff <= fin_ff;
               prefilled_ff <= prog_ff;
               job_total_ff <= tot_ff;
               // Only the final result of a schedule step carries the totals.
               if (!more) begin
                  decode_ff <= (cmd_ff == CMD_SCHED) ? dec_tokens : '0;
                  active_ff <= (cmd_ff == CMD_SCHED) ? act_x[ACT_W-1:0] : '0;
               end else begin
                  last_ff <= 1'b0;
               end
            end
            default: begin
               status_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.job_id = job_id_ff;
   assign rsp.chunk_tokens = chunk_tokens_ff;
   assign rsp.done_flag = done_flag_ff;
   assign rsp.prefilled_tokens = prefilled_ff;
   assign rsp.job_total = job_total_ff;
   assign rsp.decode_tokens = decode_ff;
   assign rsp.active_jobs = active_ff;
   assign rsp.last = last_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, job_count_ff > CNT_W'(MAX_JOBS))
   `ASSERT_CLK(a_read_in_range, clock, reset, ctrl.calc |-> (CNT_W'(addr_ff) < job_count_ff))
   `ASSERT_CLK(a_count_grows, clock, reset, !$past(reset) |-> (job_count_ff >= $past(job_count_ff)))
endmodule

@@ rtl/core/chunked_prefill_job_scheduler.sv @@
// Top level of the chunked prefill job scheduler.
//
//   channel   direction  handshake            contents
//   req_chan  in         valid/ready          command, token_count, job_index, decode_budget
//   rsp_chan  out        valid/ready          one result per transaction, last marks the end
//   csr_*     in         write enable, data   chunk_limit
//
// Submit and rejected commands go from idle straight to their emit step; next chunk and
// query read the entry, compute the chunk and emit. A schedule step with an empty table
// gives a single result; otherwise each job is read from the table, advanced and written
// back with its result, one table port access at a time.
// Reset is synchronous and empties the job table by clearing the job count.
// A stalled response holds the microprogram at its emit step; no request is taken meanwhile.
module chunked_prefill_job_scheduler #(
   parameter int MAX_JOBS = cpjs_pkg::MAX_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [cpjs_pkg::CHUNK_W-1:0] csr_write_data,
   cpjs_req_if.sink                     req_chan,
   cpjs_rsp_if.source                   rsp_chan
);
   import cpjs_pkg::*;

   ctrl_word_type ctrl;
   dp_status_type status;

   cpjs_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .status(status),
      .ctrl  (ctrl)
   );

   cpjs_datapath #(
      .MAX_JOBS(MAX_JOBS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .ctrl          (ctrl),
      .status        (status),
      .req           (req_chan),
      .rsp           (rsp_chan)
   );
endmodule

@@ sim/chunked_prefill_job_scheduler_checker.sv @@
// Checker that predicts and compares every result of the prefill job scheduler.
module chunked_prefill_job_scheduler_checker #(
   parameter int JOB_SLOTS = cpjs_pkg::MAX_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [cpjs_pkg::CHUNK_W-1:0] csr_write_data,
   cpjs_req_if                          req_mon,
   cpjs_rsp_if                          rsp_mon,
   output int                           fail_count,
   output int                           pending_results
);
   import cpjs_pkg::*;

   typedef struct packed {
      logic                status;
      logic [IDX_IN_W-1:0] job_id;
      logic [CHUNK_W-1:0]  chunk_tokens;
      logic                done_flag;
      logic [TOK_W-1:0]    prefilled_tokens;
      logic [TOK_W-1:0]    job_total;
      logic [TOK_W-1:0]    decode_tokens;
      logic [ACT_W-1:0]    active_jobs;
      logic                last;
   } job_result_type;

   logic [CHUNK_W-1:0] chunk_limit;
   int unsigned        job_count;
   logic [TOK_W-1:0]   job_totals [JOB_SLOTS];
   logic [TOK_W-1:0]   job_progress [JOB_SLOTS];
   logic               job_finished [JOB_SLOTS];
   job_result_type     expected_results [$];

   // Advances one job by at most the chunk limit and returns the chunk size.
   function automatic logic [CHUNK_W-1:0] take_chunk(input int unsigned slot);
      int unsigned limit;
      int unsigned remaining;
      int unsigned chunk;
      limit = (chunk_limit == '0) ? int'(DEFAULT_CHUNK) : int'(chunk_limit);
      if (job_finished[slot]) begin
         return '0;
      end
      if (job_progress[slot] >= job_totals[slot]) begin
         job_finished[slot] = 1'b1;
         return '0;
      end
      remaining = 32'(job_totals[slot]) - 32'(job_progress[slot]);
      chunk = (remaining < limit) ? remaining : limit;
      job_progress[slot] = job_progress[slot] + chunk[TOK_W-1:0];
      job_finished[slot] = (job_progress[slot] >= job_totals[slot]);
      return chunk[CHUNK_W-1:0];
   endfunction

   function automatic job_result_type job_view(input int unsigned slot,
                                               input logic [CHUNK_W-1:0] chunk);
      job_result_type r;
      r = '0;
      r.job_id = slot[IDX_IN_W-1:0];
      r.chunk_tokens = chunk;
      r.done_flag = job_finished[slot];
      r.prefilled_tokens = job_progress[slot];
      r.job_total = job_totals[slot];
      return r;
   endfunction

   task automatic predict_command(input cmd_type cmd, input logic [TOK_W-1:0] tokens,
                                  input logic [IDX_IN_W-1:0] index,
                                  input logic [TOK_W-1:0] budget);
      job_result_type     r;
      logic [CHUNK_W-1:0] chunks [JOB_SLOTS];
      int unsigned        chunk_sum;
      int unsigned        active;
      r = '0;
      r.last = 1'b1;
      case (cmd)
         CMD_SUBMIT: begin
            if (tokens == '0 || job_count >= JOB_SLOTS) begin
               r.status = 1'b1;
            end else begin
               job_totals[job_count] = tokens;
               job_progress[job_count] = '0;
               job_finished[job_count] = 1'b0;
               r.job_id = job_count[IDX_IN_W-1:0];
               r.job_total = tokens;
               job_count++;
            end
            expected_results.push_back(r);
         end
         CMD_NEXT, CMD_QUERY: begin
            if (index >= job_count) begin
               r.status = 1'b1;
               r.job_id = index;
               r.done_flag = 1'b1;
            end else begin
               r = job_view(index, (cmd == CMD_NEXT) ? take_chunk(index) : '0);
               r.last = 1'b1;
            end
            expected_results.push_back(r);
         end
         default: begin
            if (job_count == 0) begin
               r.decode_tokens = budget;
               expected_results.push_back(r);
            end else begin
               chunk_sum = 0;
               active = 0;
               for (int unsigned j = 0; j < job_count; j++) begin
                  chunks[j] = take_chunk(j);
                  chunk_sum += 32'(chunks[j]);
                  if (chunks[j] != '0) begin
                     active++;
                  end
               end
               for (int unsigned j = 0; j < job_count; j++) begin
                  r = job_view(j, chunks[j]);
                  if (j + 1 == job_count) begin
                     r.decode_tokens = (chunk_sum < budget) ? budget - chunk_sum[TOK_W-1:0] : '0;
                     r.active_jobs = active[ACT_W-1:0];
                     r.last = 1'b1;
                  end
                  expected_results.push_back(r);
               end
            end
         end
      endcase
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      job_result_type want;
      if (reset) begin
         chunk_limit = DEFAULT_CHUNK;
         job_count = 0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: result transaction with nothing expected, job_id 0x%0h",
                        $time, rsp_mon.job_id);
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_mon.status);
               check_field("job_id", want.job_id, rsp_mon.job_id);
               check_field("chunk_tokens", want.chunk_tokens, rsp_mon.chunk_tokens);
               check_field("done_flag", want.done_flag, rsp_mon.done_flag);
               check_field("prefilled_tokens", want.prefilled_tokens,
                           rsp_mon.prefilled_tokens);
               check_field("job_total", want.job_total, rsp_mon.job_total);
               check_field("decode_tokens", want.decode_tokens, rsp_mon.decode_tokens);
               check_field("active_jobs", want.active_jobs, rsp_mon.active_jobs);
               check_field("last", want.last, rsp_mon.last);
            end
         end
         if (csr_write_en) begin
            chunk_limit = csr_write_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_command(cmd_type'(req_mon.command), req_mon.token_count,
                            req_mon.job_index, req_mon.decode_budget);
         end
      end
      pending_results = expected_results.size();
   end

endmodule

@@ sim/tb_chunked_prefill_job_scheduler.sv @@
// Testbench top: drives commands and chunk limits into the scheduler and gives the verdict.
module tb_chunked_prefill_job_scheduler;
   import cpjs_pkg::*;

   localparam int LONG_HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 25;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic [CHUNK_W-1:0] csr_write_data;
   int                 fail_count;
   int                 pending_results;
   bit                 ready_stalls;
   bit                 sender_gaps;
   bit                 hold_requested;

   cpjs_req_if req_chan ();
   cpjs_rsp_if rsp_chan ();

   chunked_prefill_job_scheduler u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan)
   );

   chunked_prefill_job_scheduler_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offers one command and returns on the falling edge after it is taken, or after a random gap with valid low.
   task automatic send_request(input cmd_type cmd, input logic [TOK_W-1:0] tokens,
                               input logic [IDX_IN_W-1:0] index,
                               input logic [TOK_W-1:0] budget);
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.token_count <= tokens;
      req_chan.job_index <= index;
      req_chan.decode_budget <= budget;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic send_random_request();
      cmd_type          cmd;
      logic [TOK_W-1:0] tokens;
      logic [TOK_W-1:0] budget;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) cmd = CMD_SUBMIT;
      else if (pick < 50) cmd = CMD_NEXT;
      else if (pick < 80) cmd = CMD_SCHED;
      else cmd = CMD_QUERY;
      case ($urandom_range(0, 9))
         0: tokens = '0;
         1, 2: tokens = TOK_W'($urandom_range(0, 20'hFFFFF));
         default: tokens = TOK_W'($urandom_range(1, 3000));
      endcase
      budget = ($urandom_range(0, 2) == 0) ? TOK_W'($urandom_range(0, 20'hFFFFF))
                                           : TOK_W'($urandom_range(0, 4000));
      send_request(cmd, tokens, IDX_IN_W'($urandom_range(0, 15)), budget);
   endtask

   // The scheduler returns to idle right after its last result; the wait after it covers that.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_chunk_limit(input logic [CHUNK_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin : rsp_ready_driver
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (ready_stalls && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [CHUNK_W-1:0] phase_limit;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_SUBMIT;
      req_chan.token_count = '0;
      req_chan.job_index = '0;
      req_chan.decode_budget = '0;
      ready_stalls = 1'b1;
      sender_gaps = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table, bad indices and a rejected submit, then a handful of jobs.
      send_request(CMD_SCHED, '0, '0, 20'hFFFFF);
      send_request(CMD_NEXT, '0, 4'd0, '0);
      send_request(CMD_QUERY, '0, 4'd15, '0);
      send_request(CMD_SUBMIT, '0, '0, '0);
      send_request(CMD_SUBMIT, 20'd1, '0, '0);
      send_request(CMD_SUBMIT, 20'hFFFFF, '0, '0);
      send_request(CMD_SUBMIT, 20'd512, '0, '0);
      send_request(CMD_SUBMIT, 20'd513, '0, '0);
      send_request(CMD_QUERY, '0, 4'd0, '0);
      send_request(CMD_NEXT, '0, 4'd0, '0);
      send_request(CMD_NEXT, '0, 4'd0, '0);
      send_request(CMD_QUERY, '0, 4'd4, '0);
      send_request(CMD_SCHED, '0, '0, '0);
      send_request(CMD_SCHED, '0, '0, 20'hFFFFF);
      send_request(CMD_NEXT, '0, 4'd3, '0);

      // A zero limit behaves like the default chunk.
      wait_idle();
      write_chunk_limit('0);
      send_request(CMD_SCHED, '0, '0, 20'd1000);
      send_request(CMD_NEXT, '0, 4'd1, '0);

      wait_idle();
      write_chunk_limit(16'hFFFF);
      send_request(CMD_SCHED, '0, '0, 20'd70000);
      send_request(CMD_NEXT, '0, 4'd1, '0);

      wait_idle();
      write_chunk_limit(16'd1);
      send_request(CMD_SUBMIT, 20'd3, '0, '0);
      send_request(CMD_NEXT, '0, 4'd4, '0);
      send_request(CMD_SCHED, '0, '0, 20'd5);
      send_request(CMD_QUERY, '0, 4'd4, '0);

      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         case (phase)
            0: phase_limit = CHUNK_W'($urandom_range(2, 64));
            1: phase_limit = 16'd1;
            2: phase_limit = CHUNK_W'($urandom_range(65, 16'hFFFF));
            3: phase_limit = '0;
            default: phase_limit = 16'hFFFF;
         endcase
         write_chunk_limit(phase_limit);
         // The result side holds off while commands keep coming, so the block backs up.
         if (phase == 1) begin
            hold_requested = 1'b1;
         end
         if (phase == 4) begin
            ready_stalls = 1'b0;
            sender_gaps = 1'b0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random_request();
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : run_limit
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cpjs_pkg.sv
rtl/core/cpjs_req_if.sv
rtl/core/cpjs_rsp_if.sv
rtl/core/cpjs_ram.sv
rtl/core/cpjs_sequencer.sv
rtl/core/cpjs_datapath.sv
rtl/core/chunked_prefill_job_scheduler.sv
sim/chunked_prefill_job_scheduler_checker.sv
sim/tb_chunked_prefill_job_scheduler.sv
